// ===== rtl/poly1305_mac_defines.svh =====
// Assertion macros used by the poly1305 back end.
// No dependencies.
`ifndef POLY1305_MAC_DEFINES_SVH
`define POLY1305_MAC_DEFINES_SVH
`define P1305_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define P1305_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`endif

// ===== rtl/p1305_pkg.sv =====
// Types and constants for the poly1305 authenticator.
// Used by all poly1305 RTL modules.
package p1305_pkg;
   localparam int QueueDepth = 2;
   localparam logic [63:0] ClampLow  = 64'h0ffffffc0fffffff;
   localparam logic [63:0] ClampHigh = 64'h0ffffffc0ffffffc;
   localparam logic [1:0] CsrRLow  = 2'd0;
   localparam logic [1:0] CsrRHigh = 2'd1;
   localparam logic [1:0] CsrSLow  = 2'd2;
   localparam logic [1:0] CsrSHigh = 2'd3;

   typedef struct packed {
      logic [63:0] block_low;
      logic [63:0] block_high;
      logic [4:0]  block_length;
      logic        last_block;
   } req_type;

   typedef struct packed {
      logic [63:0] tag_low;
      logic [63:0] tag_high;
   } rsp_type;

   // classified work for the back end: padded 129-bit block
   typedef struct packed {
      logic [128:0] msg;
      logic         absorb;
      logic         last;
   } work_type;
endpackage

// ===== rtl/poly1305_mac.sv =====
// Poly1305 one-time authenticator: 16-byte message blocks in, 128-bit tags out.
// An item is registered in the front queue before the back end takes it. An absorbed
// block then holds the back end for a take, five product rows, a fold, a final reduce
// and a tag step; a count-zero block for a take and a tag step. The tag is readable
// after the tag step, and a last block waits while an earlier tag is unread. The user
// must write key registers through the csr_ port while idle; the block does not enforce it.
module poly1305_mac #(
   parameter int QueueDepth = p1305_pkg::QueueDepth
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  p1305_pkg::req_type req_data,
   output logic               empty,
   input  logic               pop,
   output p1305_pkg::rsp_type rsp_data,
   input  logic               csr_write,
   input  logic [1:0]         csr_index,
   input  logic [63:0]        csr_data
);
   import p1305_pkg::*;
   logic [63:0] r_lo_ff, r_hi_ff, s_lo_ff, s_hi_ff;
   logic        wv, wt, rv;
   work_type    w;

   always_ff @(posedge clock) begin
      if (reset) begin
         r_lo_ff <= '0;
         r_hi_ff <= '0;
         s_lo_ff <= '0;
         s_hi_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CsrRLow:  r_lo_ff <= csr_data;
            CsrRHigh: r_hi_ff <= csr_data;
            CsrSLow:  s_lo_ff <= csr_data;
            CsrSHigh: s_hi_ff <= csr_data;
            default: ;
         endcase
      end
   end

   p1305_front #(.Depth(QueueDepth)) u_front (
      .clock, .reset, .push, .full, .req(req_data),
      .work_valid(wv), .work_take(wt), .work(w)
   );

   p1305_back u_back (
      .clock, .reset, .key_r({r_hi_ff, r_lo_ff}), .key_s({s_hi_ff, s_lo_ff}),
      .work_valid(wv), .work_take(wt), .work(w),
      .rsp_valid(rv), .rsp_take(pop), .rsp(rsp_data)
   );

   assign empty = !rv;
endmodule

// ===== rtl/p1305_front.sv =====
// Front end: pads and classifies message blocks, queues them.
// Depends on p1305_pkg.
module p1305_front #(
   parameter int Depth = p1305_pkg::QueueDepth
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   output logic                full,
   input  p1305_pkg::req_type  req,
   output logic                work_valid,
   input  logic                work_take,
   output p1305_pkg::work_type work
);
   import p1305_pkg::*;
   localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

   work_type        mem_ff [Depth];
   logic [AW-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [AW:0]     cnt_ff, cnt_in;
   work_type        cls;
   logic [4:0]      len;
   logic [128:0]    data, mask;

   always_comb begin
      len = (req.block_length > 5'd16) ? 5'd16 : req.block_length;
      data = {1'b0, req.block_high, req.block_low};
      mask = (129'd1 << {len, 3'b000}) - 129'd1;
      cls.msg = (data & mask) | (129'd1 << {len, 3'b000});
      cls.absorb = (len != 5'd0);
      cls.last = req.last_block;
   end

   assign full = (cnt_ff == (AW+1)'(Depth));
   assign work_valid = (cnt_ff != '0);
   assign work = mem_ff[rd_ff];

   always_comb begin
      wr_in = wr_ff;
      rd_in = rd_ff;
      if (push && !full) wr_in = (wr_ff == AW'(Depth-1)) ? '0 : wr_ff + 1'b1;
      if (work_take && work_valid) rd_in = (rd_ff == AW'(Depth-1)) ? '0 : rd_ff + 1'b1;
      cnt_in = cnt_ff + (AW+1)'(push && !full) - (AW+1)'(work_take && work_valid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push && !full) mem_ff[wr_ff] <= cls;
   end
endmodule

// ===== rtl/p1305_back.sv =====
// Back end: accumulate and multiply by r modulo 2^130-5, tag output.
// Depends on p1305_pkg and poly1305_mac_defines.svh.
`include "poly1305_mac_defines.svh"
module p1305_back (
   input  logic                clock,
   input  logic                reset,
   input  logic [127:0]        key_r,
   input  logic [127:0]        key_s,
   input  logic                work_valid,
   output logic                work_take,
   input  p1305_pkg::work_type work,
   output logic                rsp_valid,
   input  logic                rsp_take,
   output p1305_pkg::rsp_type  rsp
);
   import p1305_pkg::*;
   typedef enum logic [2:0] {IDLE, MUL, RED, FIN, OUT} state_type;
   localparam logic [130:0] PrimeP = {1'b0, 130'h3fffffffffffffffffffffffffffffffb};

   state_type     state_ff;
   logic [129:0]  acc_ff;
   logic [130:0]  h_ff;       // accumulator plus block, not reduced
   logic [127:0]  r_ff;       // clamped r
   logic [2:0]    row_ff;     // product row being formed, counts down
   logic [163:0]  sum_ff;     // rows combined high row first
   logic [130:0]  fold_ff;
   logic          last_ff;
   logic          rsp_valid_ff;
   rsp_type       rsp_ff;
   logic [26:0]   h_limb [5];
   logic [25:0]   r_limb [5];
   logic [28:0]   r_sel [5];
   logic [55:0]   prod [5];
   logic [2:0]    ridx;
   logic [58:0]   row;
   logic [33:0]   over;
   logic [130:0]  red1;
   logic [130:0]  red2;
   logic [131:0]  sub;

   // 26-bit limbs; the top limb of h keeps the carry out of bit 129
   always_comb begin
      for (int j = 0; j < 4; j++) begin
         h_limb[j] = {1'b0, h_ff[26*j +: 26]};
         r_limb[j] = r_ff[26*j +: 26];
      end
      h_limb[4] = h_ff[130:104];
      r_limb[4] = {2'b00, r_ff[127:104]};
   end

   // one product row per cycle: five 27x29 multiplies
   always_comb begin
      row = '0;
      for (int j = 0; j < 5; j++) begin
         if (3'(j) <= row_ff) begin
            ridx = row_ff - 3'(j);
            r_sel[j] = {3'b000, r_limb[ridx]};
         end else begin
            // terms past 2^130 come back times 5
            ridx = row_ff + 3'(5 - j);
            r_sel[j] = {3'b000, r_limb[ridx]} + {1'b0, r_limb[ridx], 2'b00};
         end
         prod[j] = 56'(h_limb[j]) * 56'(r_sel[j]);
         row = row + 59'(prod[j]);
      end
   end

   // fold bits above 130 back in times 5
   assign over = sum_ff[163:130];
   assign red1 = 131'(sum_ff[129:0]) + 131'(over) + (131'(over) << 2);
   assign red2 = 131'(fold_ff[129:0]) + (fold_ff[130] ? 131'd5 : 131'd0);
   assign sub  = {1'b0, red2} - {1'b0, PrimeP};

   assign work_take = (state_ff == IDLE) && work_valid &&
                      !(work.last && rsp_valid_ff && !rsp_take);
   assign rsp_valid = rsp_valid_ff;
   assign rsp = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         acc_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_take && rsp_valid_ff) rsp_valid_ff <= 1'b0;
         case (state_ff)
            IDLE: begin
               if (work_take) begin
                  last_ff <= work.last;
                  if (work.absorb) begin
                     h_ff <= 131'(acc_ff) + 131'(work.msg);
                     r_ff <= key_r & {ClampHigh, ClampLow};
                     row_ff <= 3'd4;
                     sum_ff <= '0;
                     state_ff <= MUL;
                  end else begin
                     state_ff <= OUT;
                  end
               end
            end
            MUL: begin
               sum_ff <= (sum_ff << 26) + 164'(row);
               row_ff <= row_ff - 3'd1;
               if (row_ff == 3'd0) state_ff <= RED;
            end
            RED: begin
               fold_ff <= red1;
               state_ff <= FIN;
            end
            FIN: begin
               state_ff <= OUT;
               if (!sub[131]) acc_ff <= sub[129:0];
               else acc_ff <= red2[129:0];
            end
            OUT: begin
               state_ff <= IDLE;
               if (last_ff) begin
                  {rsp_ff.tag_high, rsp_ff.tag_low} <= acc_ff[127:0] + key_s;
                  rsp_valid_ff <= 1'b1;
                  acc_ff <= '0;
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   `P1305_NEVER(a_no_overwrite, clock, reset,
      rsp_valid_ff && !rsp_take && state_ff == OUT && last_ff, "tag overwritten")
   `P1305_ASSERT(a_acc_reduced, clock, reset,
      acc_ff < 130'h3fffffffffffffffffffffffffffffffb, "accumulator not reduced")
   `P1305_ASSERT(a_take_idle, clock, reset,
      !work_take || state_ff == IDLE, "take while busy")
endmodule
